// File: hw/rtl/u8d_pkg.sv
// Shared types and constants of the UTF-8 stream decoder.
`timescale 1ns / 1ps

package u8d_pkg;

  // Widths of the beat fields
  localparam int unsigned U8D_BYTE_W = 8;
  localparam int unsigned U8D_CP_W   = 21;
  localparam int unsigned U8D_USED_W = 3;
  localparam int unsigned U8D_CNT_W  = 3;

  // Default depth of the command queue between front and back
  localparam int unsigned U8D_QDEPTH = 4;

  // Replacement character U+FFFD
  localparam logic [U8D_CP_W-1:0] U8D_REPLACEMENT = 21'h00FFFD;

  // One command per input byte that gives results: rep_cnt replacement beats, then an optional good beat
  typedef struct packed {
    logic [U8D_CNT_W-1:0]  rep_cnt;
    logic                  tail_v;
    logic [U8D_CP_W-1:0]   tail_cp;
    logic [U8D_USED_W-1:0] tail_used;
  } u8d_cmd_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } u8d_qstat_t;

endpackage

// File: hw/rtl/u8d_if.sv
// Valid/ready channel interfaces for decoder input bytes and decoded results.
`timescale 1ns / 1ps

interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface u8d_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        bad_sequence;
  logic [2:0]  bytes_used;
  logic        run_end;

  modport source (output valid, output code_point, output bad_sequence,
                  output bytes_used, output run_end, input ready);
  modport sink   (input valid, input code_point, input bad_sequence,
                  input bytes_used, input run_end, output ready);
endinterface

// File: hw/rtl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: front, command queue and back.
//
//   port    dir  beat payload                                         role
//   in_i    in   data_byte[7:0], final_byte                           raw text bytes
//   out_o   out  code_point[20:0], bad_sequence, bytes_used[2:0],     decoded results
//                run_end
//
// Takes one byte per cycle while the command queue has room; a byte that gives
// results becomes one command holding one to four of them, a byte that gives none
// pushes nothing. The back emits one result per cycle while the output is ready,
// so a byte with k results holds it for k beats; the queue (QDepth commands)
// absorbs those bursts, and each command passes through it and the back's register.
// Reset clears the sequence state and the queue; no clearing pass is needed.
// A stalled output backs up the queue, and the input stalls only once it is full.
`timescale 1ns / 1ps

module utf8_stream_decoder
  import u8d_pkg::*;
#(
  parameter int unsigned QDepth = U8D_QDEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  u8d_in_if.sink     in_i,
  u8d_out_if.source  out_o
);

  u8d_cmd_t   push_cmd;
  u8d_cmd_t   head_cmd;
  u8d_qstat_t qstat;
  logic       push;
  logic       pop;

  // Classify bytes
  u8d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_i.valid),
    .data_byte_i  (in_i.data_byte),
    .final_byte_i (in_i.final_byte),
    .ready_o      (in_i.ready),
    .qstat_i      (qstat),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // Queue commands
  u8d_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .qstat_o (qstat)
  );

  // Emit results
  u8d_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (head_cmd),
    .qstat_i        (qstat),
    .pop_o          (pop),
    .valid_o        (out_o.valid),
    .ready_i        (out_o.ready),
    .code_point_o   (out_o.code_point),
    .bad_sequence_o (out_o.bad_sequence),
    .bytes_used_o   (out_o.bytes_used),
    .run_end_o      (out_o.run_end)
  );

endmodule

// File: hw/rtl/u8d_front.sv
// Front end: classifies each byte, tracks the open sequence and issues commands.
`timescale 1ns / 1ps

module u8d_front
  import u8d_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [U8D_BYTE_W-1:0] data_byte_i,
  input  logic                  final_byte_i,
  output logic                  ready_o,
  input  u8d_qstat_t            qstat_i,
  output logic                  push_o,
  output u8d_cmd_t              cmd_o
);

  logic [2:0]          exp_q, exp_d;
  logic [1:0]          held_q, held_d;
  logic [U8D_CP_W-1:0] part_q, part_d;

  logic                accept;
  logic                is_cont;
  logic                fresh;
  logic [1:0]          held_inc;
  logic [U8D_CP_W-1:0] cont_val;
  u8d_cmd_t            cmd;

  assign ready_o  = !qstat_i.full;
  assign accept   = valid_i && ready_o;
  assign is_cont  = (data_byte_i[7:6] == 2'b10);
  assign held_inc = held_q + 2'd1;
  assign cont_val = {part_q[U8D_CP_W-7:0], data_byte_i[5:0]};

  // Decode the byte against the open sequence
  always_comb begin
    exp_d  = exp_q;
    held_d = held_q;
    part_d = part_q;
    cmd    = '0;
    fresh  = 1'b1;

    if (exp_q != 3'd0) begin
      if (is_cont) begin
        fresh = 1'b0;
        if (({1'b0, held_inc} + 3'd1) >= exp_q) begin
          // sequence complete
          cmd.tail_v    = 1'b1;
          cmd.tail_cp   = cont_val;
          cmd.tail_used = exp_q;
          exp_d  = 3'd0;
          held_d = 2'd0;
          part_d = '0;
        end else if (final_byte_i) begin
          // truncated at end of text: lead plus every continuation taken
          cmd.rep_cnt = {1'b0, held_inc} + 3'd1;
          exp_d  = 3'd0;
          held_d = 2'd0;
          part_d = '0;
        end else begin
          part_d = cont_val;
          held_d = held_inc;
        end
      end else begin
        // broken sequence: flush lead and held continuations
        cmd.rep_cnt = {1'b0, held_q} + 3'd1;
        exp_d  = 3'd0;
        held_d = 2'd0;
        part_d = '0;
      end
    end

    // Take the byte as a new lead
    if (fresh) begin
      held_d = 2'd0;
      if (!data_byte_i[7]) begin
        cmd.tail_v    = 1'b1;
        cmd.tail_cp   = {13'd0, data_byte_i};
        cmd.tail_used = 3'd1;
      end else if (data_byte_i[7:5] == 3'b110) begin
        exp_d  = 3'd2;
        part_d = {16'd0, data_byte_i[4:0]};
      end else if (data_byte_i[7:4] == 4'b1110) begin
        exp_d  = 3'd3;
        part_d = {17'd0, data_byte_i[3:0]};
      end else if (data_byte_i[7:3] == 5'b11110) begin
        exp_d  = 3'd4;
        part_d = {18'd0, data_byte_i[2:0]};
      end else begin
        cmd.rep_cnt = cmd.rep_cnt + 3'd1;
      end
      if (final_byte_i && (exp_d != 3'd0)) begin
        cmd.rep_cnt = cmd.rep_cnt + 3'd1;
        exp_d  = 3'd0;
        part_d = '0;
      end
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept && ((cmd.rep_cnt != 3'd0) || cmd.tail_v);

  // Hold sequence state between beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q  <= 3'd0;
      held_q <= 2'd0;
      part_q <= '0;
    end else if (accept) begin
      exp_q  <= exp_d;
      held_q <= held_d;
      part_q <= part_d;
    end
  end

`ifndef ASSERT_OFF
  a_held_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_q != 3'd0) |-> (({1'b0, held_q} + 3'd2) <= exp_q))
    else $error("held continuations reached sequence length");
  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && final_byte_i) |=> (exp_q == 3'd0))
    else $error("sequence left open after final byte");
`endif

endmodule

// File: hw/rtl/u8d_fifo.sv
// Short command queue between the front and the back.
`timescale 1ns / 1ps

module u8d_fifo
  import u8d_pkg::*;
#(
  parameter int unsigned Depth = U8D_QDEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  u8d_cmd_t   wdata_i,
  input  logic       pop_i,
  output u8d_cmd_t   rdata_o,
  output u8d_qstat_t qstat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u8d_cmd_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign qstat_o.full  = (cnt_q == CntW'(Depth));
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign rdata_o       = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Store commands
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !qstat_o.full)
    else $error("push into full queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");
`endif

endmodule

// File: hw/rtl/u8d_back.sv
// Back end: expands each command into result beats, one per cycle while the output is ready.
`timescale 1ns / 1ps

module u8d_back
  import u8d_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  u8d_cmd_t              cmd_i,
  input  u8d_qstat_t            qstat_i,
  output logic                  pop_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [U8D_CP_W-1:0]   code_point_o,
  output logic                  bad_sequence_o,
  output logic [U8D_USED_W-1:0] bytes_used_o,
  output logic                  run_end_o
);

  u8d_cmd_t             cmd_q;
  logic                 valid_q;
  logic [U8D_CNT_W-1:0] idx_q;

  logic [U8D_CNT_W-1:0] total;
  logic                 is_rep;
  logic                 last;
  logic                 fire;
  logic                 load;

  assign total  = cmd_q.rep_cnt + {{(U8D_CNT_W-1){1'b0}}, cmd_q.tail_v};
  assign is_rep = (idx_q < cmd_q.rep_cnt);
  assign last   = ((idx_q + 3'd1) == total);
  assign fire   = valid_q && ready_i;
  assign load   = !valid_q || (fire && last);
  assign pop_o  = load && !qstat_i.empty;

  // Drive the current beat
  assign valid_o        = valid_q;
  assign code_point_o   = is_rep ? U8D_REPLACEMENT : cmd_q.tail_cp;
  assign bad_sequence_o = is_rep;
  assign bytes_used_o   = is_rep ? 3'd1 : cmd_q.tail_used;
  assign run_end_o      = last;

  // Load the next command or step through the current one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= !qstat_i.empty;
      idx_q   <= '0;
    end else if (fire) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
  end

`ifndef ASSERT_OFF
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (idx_q < total))
    else $error("beat index past end of command");
  a_mid_run_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !last) |=> (valid_q && (idx_q == ($past(idx_q) + 3'd1))))
    else $error("command dropped before its last beat");
`endif

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the UTF-8 stream decoder.
`timescale 1ns / 1ps

module tb_top;
  import u8d_pkg::*;

  // One decoded character as seen on the result channel
  typedef struct packed {
    logic [U8D_CP_W-1:0]   code_point;
    logic                  bad_sequence;
    logic [U8D_USED_W-1:0] bytes_used;
    logic                  run_end;
  } u8_result_t;

  // One directed stimulus row; known marks a hand-written expectation
  typedef struct packed {
    logic [U8D_BYTE_W-1:0] data_byte;
    logic                  final_byte;
    logic                  known;
    u8_result_t            want;
  } stim_row_t;

  // Top-bit tags of the byte classes
  localparam logic [1:0] CONT_TAG  = 2'b10;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  localparam int RANDOM_BYTES = 94;
  localparam int CALM_AFTER   = 70;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk_i;
  logic rst_ni;

  u8d_in_if  in_if ();
  u8d_out_if out_if ();

  utf8_stream_decoder dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Decoder state mirror
  logic [2:0]          open_len;
  logic [1:0]          held_count;
  logic [U8D_CP_W-1:0] acc_value;

  u8_result_t awaited_chars [$];
  u8_result_t step_chars [$];
  stim_row_t  directed_rows [$];

  logic mismatch_seen;
  logic calm;
  int   cycle_count;
  int   bytes_sent;
  int   finals_sent;
  int   chars_checked;
  int   replacements_seen;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still awaited",
               cycle_count, awaited_chars.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic stim_row_t pick(input logic [7:0] b, input logic fin);
    stim_row_t r;
    r = '0;
    r.data_byte  = b;
    r.final_byte = fin;
    return r;
  endfunction

  function automatic stim_row_t pick_known(input logic [7:0] b, input logic fin,
                                           input logic [U8D_CP_W-1:0] cp,
                                           input logic bad, input logic [2:0] used);
    stim_row_t r;
    r = pick(b, fin);
    r.known = 1'b1;
    r.want  = '{cp, bad, used, 1'b1};
    return r;
  endfunction

  // Drop the open sequence: one replacement for the lead, one per held continuation
  task automatic flush_open();
    int k;
    step_chars.push_back('{U8D_REPLACEMENT, 1'b1, 3'd1, 1'b0});
    for (k = 0; k < int'(held_count); k++)
      step_chars.push_back('{U8D_REPLACEMENT, 1'b1, 3'd1, 1'b0});
    open_len   = '0;
    held_count = '0;
    acc_value  = '0;
  endtask

  // Advance the decoder mirror by one byte; queue its characters when keep is set
  task automatic decode_byte(input logic [7:0] b, input logic fin, input logic keep);
    logic fresh;
    int   k;
    fresh = 1'b1;
    step_chars.delete();
    if (open_len != 0) begin
      if (b[7:6] == CONT_TAG) begin
        fresh      = 1'b0;
        acc_value  = {acc_value[U8D_CP_W-7:0], b[5:0]};
        held_count = held_count + 2'd1;
        if (int'(held_count) + 1 >= int'(open_len)) begin
          step_chars.push_back('{acc_value, 1'b0, open_len, 1'b0});
          open_len   = '0;
          held_count = '0;
          acc_value  = '0;
        end else if (fin) begin
          flush_open();
        end
      end else begin
        flush_open();
      end
    end
    if (fresh) begin
      held_count = '0;
      if (b[7] == 1'b0) begin
        step_chars.push_back('{{13'd0, b}, 1'b0, 3'd1, 1'b0});
      end else if (b[7:5] == LEAD2_TAG) begin
        open_len  = 3'd2;
        acc_value = {16'd0, b[4:0]};
      end else if (b[7:4] == LEAD3_TAG) begin
        open_len  = 3'd3;
        acc_value = {17'd0, b[3:0]};
      end else if (b[7:3] == LEAD4_TAG) begin
        open_len  = 3'd4;
        acc_value = {18'd0, b[2:0]};
      end else begin
        step_chars.push_back('{U8D_REPLACEMENT, 1'b1, 3'd1, 1'b0});
      end
      if (fin && open_len != 0) flush_open();
    end
    if (step_chars.size() > 0) step_chars[step_chars.size()-1].run_end = 1'b1;
    if (keep) begin
      for (k = 0; k < step_chars.size(); k++) awaited_chars.push_back(step_chars[k]);
    end
  endtask

  // Offer one byte, with an occasional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b, input logic fin, input logic known,
                           input u8_result_t want);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.final_byte <= fin;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    decode_byte(b, fin, !known);
    if (known) awaited_chars.push_back(want);
    bytes_sent++;
    if (fin) finals_sent++;
  endtask

  // Result side: stall in bursts, none once calm
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  // Check every result beat against the oldest awaited character
  always @(posedge clk_i) begin
    u8_result_t got;
    u8_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.code_point, out_if.bad_sequence, out_if.bytes_used, out_if.run_end};
      if (awaited_chars.size() == 0) begin
        $error("unexpected result beat: code_point %h", got.code_point);
        mismatch_seen = 1'b1;
      end else begin
        want = awaited_chars.pop_front();
        if (got.code_point !== want.code_point) begin
          $error("code_point: expected %h, got %h", want.code_point, got.code_point);
          mismatch_seen = 1'b1;
        end
        if (got.bad_sequence !== want.bad_sequence) begin
          $error("bad_sequence: expected %b, got %b", want.bad_sequence, got.bad_sequence);
          mismatch_seen = 1'b1;
        end
        if (got.bytes_used !== want.bytes_used) begin
          $error("bytes_used: expected %0d, got %0d", want.bytes_used, got.bytes_used);
          mismatch_seen = 1'b1;
        end
        if (got.run_end !== want.run_end) begin
          $error("run_end: expected %b, got %b", want.run_end, got.run_end);
          mismatch_seen = 1'b1;
        end
        chars_checked++;
        if (want.bad_sequence) replacements_seen++;
      end
    end
  end

  // Stimulus
  initial begin
    logic [7:0] grp [5];
    int         glen;
    int         need;
    int         kind;
    int         cut;
    int         i;
    logic [7:0] b;
    logic       fin;

    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.data_byte   = '0;
    in_if.final_byte  = 1'b0;
    open_len          = '0;
    held_count        = '0;
    acc_value         = '0;
    mismatch_seen     = 1'b0;
    calm              = 1'b0;
    cycle_count       = 0;
    bytes_sent        = 0;
    finals_sent       = 0;
    chars_checked     = 0;
    replacements_seen = 0;

    directed_rows = '{
      // extremes of the single-byte range and stray bytes
      pick_known(8'h00, 1'b0, 21'h000000, 1'b0, 3'd1),
      pick_known(8'h7f, 1'b0, 21'h00007f, 1'b0, 3'd1),
      pick_known(8'h80, 1'b0, U8D_REPLACEMENT, 1'b1, 3'd1),
      pick_known(8'hff, 1'b0, U8D_REPLACEMENT, 1'b1, 3'd1),
      pick_known(8'hf8, 1'b0, U8D_REPLACEMENT, 1'b1, 3'd1),
      // lead that ends the text
      pick_known(8'hc3, 1'b1, U8D_REPLACEMENT, 1'b1, 3'd1),
      // two, three and four byte sequences, the last at the top of the range
      pick(8'hc2, 1'b0), pick(8'ha9, 1'b0),
      pick(8'he2, 1'b0), pick(8'h82, 1'b0), pick(8'hac, 1'b0),
      pick(8'hf7, 1'b0), pick(8'hbf, 1'b0), pick(8'hbf, 1'b0), pick(8'hbf, 1'b0),
      // broken sequence with two held continuations
      pick(8'hf0, 1'b0), pick(8'h80, 1'b0), pick(8'h80, 1'b0), pick(8'h41, 1'b0),
      // truncated ends
      pick(8'he2, 1'b0), pick(8'h82, 1'b1),
      pick(8'hf1, 1'b0), pick(8'h80, 1'b0), pick(8'h80, 1'b1),
      // overlong form passes through
      pick(8'hc0, 1'b0), pick(8'h80, 1'b0)
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part
    foreach (directed_rows[i])
      send_byte(directed_rows[i].data_byte, directed_rows[i].final_byte,
                directed_rows[i].known, directed_rows[i].want);

    // Hold the sender until the decoder has drained
    in_if.valid <= 1'b0;
    while (awaited_chars.size() != 0) @(posedge clk_i);

    // Random part: mostly well-formed sequences, some broken ones and noise
    while (bytes_sent - directed_rows.size() < RANDOM_BYTES) begin
      calm = (bytes_sent - directed_rows.size() >= CALM_AFTER);
      kind = $urandom_range(0, 9);
      need = $urandom_range(1, 4);
      case (need)
        1:       grp[0] = {1'b0, 7'($urandom_range(0, 127))};
        2:       grp[0] = {LEAD2_TAG, 5'($urandom_range(0, 31))};
        3:       grp[0] = {LEAD3_TAG, 4'($urandom_range(0, 15))};
        default: grp[0] = {LEAD4_TAG, 3'($urandom_range(0, 7))};
      endcase
      for (i = 1; i < need; i++) grp[i] = {CONT_TAG, 6'($urandom_range(0, 63))};
      glen = need;
      if (kind == 9) begin
        grp[0] = 8'($urandom_range(0, 255));
        glen   = 1;
      end else if (kind >= 7 && need > 1) begin
        // cut short; the next group breaks it
        glen = $urandom_range(1, need - 1);
      end
      cut = -1;
      if ($urandom_range(0, 7) == 0) cut = $urandom_range(0, glen - 1);
      for (i = 0; i < glen; i++) begin
        b   = grp[i];
        fin = (i == cut);
        send_byte(b, fin, 1'b0, '0);
      end
    end
    in_if.valid <= 1'b0;

    // Drain and let the pipeline settle
    while (awaited_chars.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d bytes (%0d with end of text), checked %0d results, %0d replacements",
             bytes_sent, finals_sent, chars_checked, replacements_seen);
    if (!mismatch_seen) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
